@@ design/bsrm_pkg.sv @@
// shared types and constants for the bmp square rotate / mirror block
package bsrm_pkg;

    // bmp layout
    localparam int unsigned HDR_LEN   = 54;
    localparam int unsigned PAL_LEN   = 1024;
    localparam int unsigned WIDTH_AT  = 18;
    localparam int unsigned HEIGHT_AT = 22;
    localparam int unsigned DEPTH_AT  = 28;
    localparam int unsigned PAL_DEPTH_MAX = 8;

    // byte counter for header and palette
    localparam int unsigned POS_W = 11;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PALETTE = 2'd1,
        PH_PIXELS  = 2'd2,
        PH_READOUT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_ROT90  = 2'd0,
        MODE_ROT180 = 2'd1,
        MODE_MIRROR = 2'd2,
        MODE_IDENT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PALETTE = 2'd1,
        KIND_PIXEL   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PASS      = 2'd1,
        ST_NOT_READY = 2'd2
    } t_status;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

endpackage

@@ design/bsrm_src_addr.sv @@
// source address of an output pixel for the selected transform
module bsrm_src_addr #(
    parameter int unsigned SIDE_W = 9,
    parameter int unsigned IDX_W  = 8,
    parameter int unsigned ADDR_W = 16
) (
    input  bsrm_pkg::t_mode    i_mode,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [SIDE_W-1:0]  i_side,
    output logic [ADDR_W-1:0]  o_addr
);

    logic [SIDE_W-1:0]       side_m1;
    logic [IDX_W-1:0]        inv_row;
    logic [IDX_W-1:0]        inv_col;
    logic [IDX_W-1:0]        src_row;
    logic [IDX_W-1:0]        src_col;
    logic [IDX_W+SIDE_W-1:0] row_base;
    logic [IDX_W+SIDE_W-1:0] full_addr;

    // mirrored coordinates
    assign side_m1 = i_side - SIDE_W'(1);
    assign inv_row = IDX_W'(side_m1 - SIDE_W'(i_row));
    assign inv_col = IDX_W'(side_m1 - SIDE_W'(i_col));

    // pick source row and column
    always_comb begin
        case (i_mode)
            bsrm_pkg::MODE_ROT90: begin
                src_row = i_col;
                src_col = inv_row;
            end
            bsrm_pkg::MODE_ROT180: begin
                src_row = inv_row;
                src_col = inv_col;
            end
            bsrm_pkg::MODE_MIRROR: begin
                src_row = i_row;
                src_col = inv_col;
            end
            default: begin
                src_row = i_row;
                src_col = i_col;
            end
        endcase
    end

    // row-major address
    assign row_base  = (IDX_W+SIDE_W)'(src_row) * (IDX_W+SIDE_W)'(i_side);
    assign full_addr = row_base + (IDX_W+SIDE_W)'(src_col);
    assign o_addr    = full_addr[ADDR_W-1:0];

endmodule

@@ design/bmp_square_rotate_mirror.sv @@
// top level: bmp parser, pixel frame store and transformed readout
// a result passes through the pending stage and then the output register after its item is accepted
// throughput: one item per cycle while the output is not stalled, set by the single write / single read pixel memory
// writes of pixel bytes for a supported size and writes during readout give no result
// reset (synchronous, active low) clears control state and mode; the pixel memory
// is not cleared, every pixel read in a frame is written earlier in that frame
module bmp_square_rotate_mirror #(
    parameter int unsigned MAX_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] command
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]  m_axis_tuser,   // [1:0] kind, [3:2] status
    output logic        m_axis_tlast
);

    localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int unsigned IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int unsigned ADDR_W = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned POS_W  = bsrm_pkg::POS_W;

    // control and header state
    bsrm_pkg::t_phase   r_phase, n_phase;
    bsrm_pkg::t_mode    r_mode;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [31:0]        r_width, n_width;
    logic [31:0]        r_height, n_height;
    logic [15:0]        r_depth, n_depth;
    logic               r_dims_ok, n_dims_ok;
    logic [SIDE_W-1:0]  r_side, n_side;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_wr_addr, n_wr_addr;

    // pending stage (memory read in flight)
    logic               r_p_valid;
    logic [7:0]         r_p_byte;
    logic [1:0]         r_p_kind;
    logic [1:0]         r_p_status;
    logic               r_p_last;
    logic               r_p_mem;

    // output register
    logic               r_o_valid;
    logic [7:0]         r_o_byte;
    logic [3:0]         r_o_user;
    logic               r_o_last;

    // pixel memory
    logic [7:0]         r_mem [DEPTH];
    logic [7:0]         r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;

    // per-item decode
    logic               p_move;
    logic               acc;
    logic               res_valid;
    logic [7:0]         res_byte;
    logic [1:0]         res_kind;
    logic [1:0]         res_status;
    logic               res_last;
    logic               res_mem;
    logic               mem_we;
    logic               mem_re;
    logic               dims_chk;
    logic               at_end;
    logic [SIDE_W-1:0]  side_m1;
    logic [SIDE_W-1:0]  side_chk;
    logic [1:0]         fld_byte;

    // handshake
    assign p_move        = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || p_move;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // square check on the captured header fields
    assign dims_chk = (r_width == r_height) && (r_width != 32'd0)
                      && (r_width <= 32'(MAX_SIDE));
    assign side_chk = dims_chk ? r_width[SIDE_W-1:0] : '0;
    assign side_m1  = r_side - SIDE_W'(1);
    assign at_end   = (SIDE_W'(r_row) == side_m1) && (SIDE_W'(r_col) == side_m1);

    // byte lane of width and height, both fields start at offset 2 mod 4
    assign fld_byte = r_pos[1:0] - 2'd2;

    // transformed source address
    bsrm_src_addr #(
        .SIDE_W (SIDE_W),
        .IDX_W  (IDX_W),
        .ADDR_W (ADDR_W)
    ) u_src_addr (
        .i_mode (r_mode),
        .i_row  (r_row),
        .i_col  (r_col),
        .i_side (r_side),
        .o_addr (rd_addr)
    );

    // phase machine and item decode
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_width    = r_width;
        n_height   = r_height;
        n_depth    = r_depth;
        n_dims_ok  = r_dims_ok;
        n_side     = r_side;
        n_row      = r_row;
        n_col      = r_col;
        n_wr_addr  = r_wr_addr;
        res_valid  = 1'b0;
        res_byte   = s_axis_tdata;
        res_kind   = bsrm_pkg::KIND_HEADER;
        res_status = bsrm_pkg::ST_OK;
        res_last   = 1'b0;
        res_mem    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        if (acc) begin
            if (s_axis_tuser == bsrm_pkg::CMD_WRITE) begin
                case (r_phase)
                    bsrm_pkg::PH_HEADER: begin
                        // capture little-endian fields
                        case (r_pos) inside
                            [POS_W'(bsrm_pkg::WIDTH_AT):POS_W'(bsrm_pkg::WIDTH_AT + 3)]:
                                n_width[8*fld_byte +: 8] = s_axis_tdata;
                            [POS_W'(bsrm_pkg::HEIGHT_AT):POS_W'(bsrm_pkg::HEIGHT_AT + 3)]:
                                n_height[8*fld_byte +: 8] = s_axis_tdata;
                            [POS_W'(bsrm_pkg::DEPTH_AT):POS_W'(bsrm_pkg::DEPTH_AT + 1)]:
                                n_depth[8*r_pos[0] +: 8] = s_axis_tdata;
                            default: ;
                        endcase
                        res_valid = 1'b1;
                        res_kind  = bsrm_pkg::KIND_HEADER;
                        n_pos     = r_pos + POS_W'(1);
                        if (r_pos == POS_W'(bsrm_pkg::HDR_LEN - 1)) begin
                            n_pos     = '0;
                            n_dims_ok = dims_chk;
                            n_side    = side_chk;
                            n_row     = '0;
                            n_col     = '0;
                            n_wr_addr = '0;
                            n_phase   = (r_depth <= 16'(bsrm_pkg::PAL_DEPTH_MAX))
                                        ? bsrm_pkg::PH_PALETTE : bsrm_pkg::PH_PIXELS;
                        end
                    end
                    bsrm_pkg::PH_PALETTE: begin
                        res_valid  = 1'b1;
                        res_kind   = bsrm_pkg::KIND_PALETTE;
                        res_status = r_dims_ok ? bsrm_pkg::ST_OK : bsrm_pkg::ST_PASS;
                        n_pos      = r_pos + POS_W'(1);
                        if (r_pos == POS_W'(bsrm_pkg::PAL_LEN - 1)) begin
                            n_pos   = '0;
                            n_phase = bsrm_pkg::PH_PIXELS;
                        end
                    end
                    bsrm_pkg::PH_PIXELS: begin
                        if (!r_dims_ok) begin
                            // unsupported size: pass bytes through
                            res_valid  = 1'b1;
                            res_kind   = bsrm_pkg::KIND_PIXEL;
                            res_status = bsrm_pkg::ST_PASS;
                        end else begin
                            mem_we    = 1'b1;
                            n_wr_addr = r_wr_addr + ADDR_W'(1);
                            if (at_end) begin
                                n_row   = '0;
                                n_col   = '0;
                                n_phase = bsrm_pkg::PH_READOUT;
                            end else if (SIDE_W'(r_col) == side_m1) begin
                                n_col = '0;
                                n_row = r_row + IDX_W'(1);
                            end else begin
                                n_col = r_col + IDX_W'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end else begin
                res_valid = 1'b1;
                res_kind  = bsrm_pkg::KIND_PIXEL;
                if (r_phase != bsrm_pkg::PH_READOUT || !r_dims_ok) begin
                    res_byte   = 8'd0;
                    res_status = bsrm_pkg::ST_NOT_READY;
                end else begin
                    // pixel readout through the memory
                    mem_re   = 1'b1;
                    res_mem  = 1'b1;
                    res_last = at_end;
                    if (at_end) begin
                        n_phase   = bsrm_pkg::PH_HEADER;
                        n_pos     = '0;
                        n_dims_ok = 1'b0;
                        n_row     = '0;
                        n_col     = '0;
                    end else if (SIDE_W'(r_col) == side_m1) begin
                        n_col = '0;
                        n_row = r_row + IDX_W'(1);
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bsrm_pkg::PH_HEADER;
            r_mode    <= bsrm_pkg::MODE_ROT90;
            r_pos     <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_depth   <= '0;
            r_dims_ok <= 1'b0;
            r_side    <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_wr_addr <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_width   <= n_width;
            r_height  <= n_height;
            r_depth   <= n_depth;
            r_dims_ok <= n_dims_ok;
            r_side    <= n_side;
            r_row     <= n_row;
            r_col     <= n_col;
            r_wr_addr <= n_wr_addr;
            if (i_cfg_we) begin
                r_mode <= bsrm_pkg::t_mode'(i_cfg_wdata);
            end
        end
    end

    // pixel memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_addr] <= s_axis_tdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // pending stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (acc && res_valid) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    // pending stage payload
    always_ff @(posedge i_clk) begin
        if (acc && res_valid) begin
            r_p_byte   <= res_byte;
            r_p_kind   <= res_kind;
            r_p_status <= res_status;
            r_p_last   <= res_last;
            r_p_mem    <= res_mem;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_byte <= r_p_mem ? r_rd_data : r_p_byte;
            r_o_user <= {r_p_status, r_p_kind};
            r_o_last <= r_p_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_byte;
    assign m_axis_tuser  = r_o_user;
    assign m_axis_tlast  = r_o_last;

endmodule
